@@ rtl/core/cpce_pkg.sv @@
// ----------------------------------------------------------------------------
// cpce_pkg
// Shared types and constants for the capsule pair collision event core.
// ----------------------------------------------------------------------------
package cpce_pkg;

  localparam int unsigned PairSlots   = 64;
  localparam int unsigned ObjectCount = 256;
  localparam int unsigned ObjW        = (ObjectCount > 1) ? $clog2(ObjectCount) : 1;
  localparam int unsigned KeyW        = 2 * ObjW;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvEnter = 2'd1,
    EvStay  = 2'd2,
    EvExit  = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic [7:0]         first_id;
    logic [7:0]         second_id;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic [29:0]        first_radius;
    logic [29:0]        first_length;
    logic [29:0]        second_radius;
    logic [29:0]        second_length;
  } query_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic       receiver;
    logic       touching;
    logic       last_of_run;
  } result_t;

  // Token passed along the cell chain for one query.
  typedef struct packed {
    logic [ObjW-1:0] key_a;
    logic [ObjW-1:0] key_b;
    logic            insert;   // store the pair in the first free cell
    logic            remove;   // clear any matching cell
    logic            found;    // some cell matched so far
  } chain_tok_t;

endpackage

@@ rtl/core/capsule_pair_collision_events_core.sv @@
// ----------------------------------------------------------------------------
// capsule_pair_collision_events_core
// A query passes the geometry step, a lookup pass along the cell row and,
// when the pair is inserted or removed, a second (update) table pass.
// One query at a time; the next is accepted only once the last result word
// of the current one has left and the core is idle again. Cost is set by the
// shared squarer and the token walk along the cell row.
// Reset empties the pair table.
// ----------------------------------------------------------------------------
module capsule_pair_collision_events_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cpce_pkg::query_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cpce_pkg::result_t out_data_o
);
  import cpce_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StGeom = 5'b00010,
    StScan = 5'b00100,
    StUpd  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [ObjW-1:0] id_a_q, id_b_q;
  logic            geom_done, touch, touch_q;
  logic            start;
  logic            found_q;
  logic            second_q;   // second result word of a pair pending
  logic            pass_upd_q; // running the update pass

  logic       tvld [PairSlots+1];
  chain_tok_t tok  [PairSlots+1];
  logic       inj_q;
  chain_tok_t inj_tok_q;

  assign start      = (state_q == StIdle) && in_valid_i;
  assign in_stall_o = (state_q != StIdle);

  cpce_geom u_geom (
    .clk_i, .rst_ni, .start_i(start), .q_i(in_data_i),
    .done_o(geom_done), .touch_o(touch)
  );

  assign tvld[0] = inj_q;
  assign tok[0]  = inj_tok_q;

  for (genvar g = 0; g < PairSlots; g++) begin : g_cell
    cpce_cell u_cell (
      .clk_i, .rst_ni,
      .tok_vld_i(tvld[g]), .tok_i(tok[g]),
      .tok_vld_o(tvld[g+1]), .tok_o(tok[g+1])
    );
  end

  // FSM: geometry, lookup pass, then (if needed) update pass, then output.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i) state_d = StGeom;
      StGeom: if (geom_done) state_d = StScan;
      StScan: if (tvld[PairSlots]) begin
        state_d = StUpd;
      end
      StUpd:  if (!pass_upd_q || tvld[PairSlots]) state_d = StOut;
      StOut:  if (!out_stall_i && (!second_q)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      inj_q      <= 1'b0;
      second_q   <= 1'b0;
      pass_upd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= 1'b0;
      if (state_q == StGeom && geom_done) inj_q <= 1'b1;
      if (state_q == StScan && tvld[PairSlots]) begin
        pass_upd_q <= (touch_q && !tok[PairSlots].found) ||
                      (!touch_q && tok[PairSlots].found);
        inj_q      <= (touch_q && !tok[PairSlots].found) ||
                      (!touch_q && tok[PairSlots].found);
        second_q   <= tok[PairSlots].found;
      end
      if (state_q == StOut && !out_stall_i) second_q <= 1'b0;
      if (state_q == StIdle) pass_upd_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      id_a_q <= in_data_i.first_id[ObjW-1:0];
      id_b_q <= in_data_i.second_id[ObjW-1:0];
    end
    if (geom_done) touch_q <= touch;
    if (state_q == StScan && tvld[PairSlots]) found_q <= tok[PairSlots].found;
    inj_tok_q.key_a  <= id_a_q;
    inj_tok_q.key_b  <= id_b_q;
    inj_tok_q.found  <= 1'b0;
    inj_tok_q.insert <= (state_q == StScan) && touch_q && !tok[PairSlots].found;
    inj_tok_q.remove <= (state_q == StScan) && !touch_q && tok[PairSlots].found;
  end

  // Result word: first of a pair goes to receiver 0, second to receiver 1.
  logic [1:0] kind;
  always_comb begin
    priority if (touch_q && !found_q) kind = EvEnter;
    else if (touch_q)                 kind = EvStay;
    else if (found_q)                 kind = EvExit;
    else                              kind = EvNone;
  end

  logic two;
  assign two = found_q;
  logic rcv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rcv_q <= 1'b0;
    else if (state_q == StOut && !out_stall_i) rcv_q <= two && !rcv_q;
  end

  assign out_valid_o            = (state_q == StOut);
  assign out_data_o.event_kind  = kind;
  assign out_data_o.receiver    = rcv_q;
  assign out_data_o.touching    = touch_q;
  assign out_data_o.last_of_run = !two || rcv_q;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accept while busy");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_of_run) |=> (state_q == StIdle))
    else $error("run did not end");
  a_recv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.receiver) |-> out_data_o.last_of_run)
    else $error("second word not last");
`endif

endmodule

@@ rtl/core/cpce_cell.sv @@
// ----------------------------------------------------------------------------
// cpce_cell
// One pair table slot: matches, inserts or clears as the token passes.
// ----------------------------------------------------------------------------
module cpce_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tok_vld_i,
  input  cpce_pkg::chain_tok_t tok_i,
  output logic                tok_vld_o,
  output cpce_pkg::chain_tok_t tok_o
);
  import cpce_pkg::*;

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic            hit;
  chain_tok_t      tok_d, tok_q;
  logic            tvld_q;

  assign hit = valid_q && ((key_q == {tok_i.key_a, tok_i.key_b}) ||
                           (key_q == {tok_i.key_b, tok_i.key_a}));

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    tok_d   = tok_i;
    if (tok_vld_i) begin
      if (hit) begin
        tok_d.found = 1'b1;
      end
      if (tok_i.remove && hit) begin
        valid_d = 1'b0;
      end
      if (tok_i.insert && !valid_q) begin
        valid_d      = 1'b1;
        key_d        = {tok_i.key_a, tok_i.key_b};
        tok_d.insert = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tvld_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tvld_q  <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tok_q <= tok_d;
  end

  assign tok_vld_o = tvld_q;
  assign tok_o     = tok_q;

endmodule

@@ rtl/core/cpce_geom.sv @@
// ----------------------------------------------------------------------------
// cpce_geom
// Touch test: four squares through one shared 34x34 squarer, one per cycle.
// ----------------------------------------------------------------------------
module cpce_geom (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cpce_pkg::query_t q_i,
  output logic            done_o,
  output logic            touch_o
);
  import cpce_pkg::*;

  logic [33:0]  hx_q, hz_q, gap_q, rad_q;
  logic [2:0]   step_q;
  logic         busy_q;
  logic [33:0]  opnd;
  logic [67:0]  sq;
  logic [69:0]  acc_q;
  logic [67:0]  rsq_q;
  logic [33:0]  vy2, span;

  function automatic logic [33:0] adiff2(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d[32]) d = -d;
    return {d[32:0], 1'b0};
  endfunction

  assign vy2  = adiff2(q_i.first_y, q_i.second_y);
  assign span = 34'(q_i.first_length) + 34'(q_i.second_length);

  always_comb begin
    unique case (step_q[1:0])
      2'd0:    opnd = hx_q;
      2'd1:    opnd = hz_q;
      2'd2:    opnd = gap_q;
      default: opnd = rad_q;
    endcase
  end
  // 34x34 square, one per cycle
  assign sq = opnd * opnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd4) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hx_q  <= adiff2(q_i.first_x, q_i.second_x);
      hz_q  <= adiff2(q_i.first_z, q_i.second_z);
      gap_q <= (vy2 > span) ? vy2 - span : '0;
      rad_q <= 34'({(31'(q_i.first_radius) + 31'(q_i.second_radius)), 1'b0});
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q < 3'd3) acc_q <= acc_q + 70'(sq);
      else if (step_q == 3'd3) rsq_q <= sq;
    end
  end

  assign done_o  = busy_q && (step_q == 3'd4);
  assign touch_o = acc_q < 70'(rsq_q);

endmodule
